// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded substring search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

    localparam int MAX_PATTERN_DEF    = 32;
    localparam int POSITION_WIDTH_DEF = 16;

    // input beat modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_SEARCHING = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_FOUND,
        DEC_MISSING
    } t_decision;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [15:0] search_limit;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] match_offset;
    } t_out_beat;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       step;
        logic [7:0] data_byte;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/bss_cell.sv =====
// ----------------------------------------------------------------------------
// bss_cell
// One pattern position: holds a pattern byte and its shift-and match bit,
// takes the match bit of its left neighbor each text step.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 6
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire bss_pkg::t_cell_ctrl i_ctrl,
    input  wire  [LEN_W-1:0]       i_len,
    input  wire                    i_prev,
    output logic                   o_match,
    output logic                   o_hit
);

    logic [7:0] r_pat;
    logic       r_match;
    logic       n_match;
    logic       w_active;
    logic       w_last;
    logic       w_load_here;

    assign w_active    = LEN_W'(INDEX) < i_len;
    assign w_last      = i_len == LEN_W'(INDEX + 1);
    assign w_load_here = i_ctrl.load && (i_len == LEN_W'(INDEX));

    assign n_match = i_prev && w_active && (r_pat == i_ctrl.data_byte);

    always_ff @(posedge i_clk) begin
        if (w_load_here) begin
            r_pat <= i_ctrl.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_match <= 1'b0;
        end else if (i_ctrl.step) begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;
    // full match completes in the last active cell on this step
    assign o_hit   = n_match && w_last;

endmodule

`default_nettype wire

// ===== rtl/bounded_substring_search_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_substring_search_unit
// Bounded substring search with a shift-and chain of pattern cells.
// ----------------------------------------------------------------------------
// Usage: one input channel (i_valid / o_ready / i_data) carries start, pattern
// and text beats; one output channel (o_valid / i_ready / o_data) returns one
// result beat per input beat, in order.
// A start beat latches the search limit and empties the pattern. Pattern beats
// append bytes into the cell chain, one cell per pattern position. Text beats
// are compared against every cell at once; each cell takes its neighbor's
// match bit, so a text byte is fully processed in the cycle it is accepted.
// The result beat is registered in the output register, or in the skid entry while the output register waits.
// Throughput: one beat per cycle while the skid entry is empty, set by the cell chain update.
// Output side has an output register plus one skid entry, so an input beat is
// still taken while a result waits; o_ready drops only when both are full.
// Reset clears length, match bits, position, limit and decision; the pattern
// bytes themselves are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_substring_search_unit #(
    parameter int MAX_PATTERN    = bss_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_WIDTH = bss_pkg::POSITION_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire bss_pkg::t_in_beat i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output bss_pkg::t_out_beat   o_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PW    = POSITION_WIDTH;

    logic [LEN_W-1:0]        r_len;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           r_limit;
    logic [PW-1:0]           r_found;
    bss_pkg::t_decision      r_dec;

    logic [LEN_W-1:0]        n_len;
    logic [PW-1:0]           n_pos;
    logic [PW-1:0]           n_limit;
    logic [PW-1:0]           n_found;
    bss_pkg::t_decision      n_dec;

    logic                    r_out_vld;
    bss_pkg::t_out_beat      r_out;
    logic                    r_skid_vld;
    bss_pkg::t_out_beat      r_skid;

    bss_pkg::t_cell_ctrl     w_ctrl;
    bss_pkg::t_out_beat      w_res;
    logic                    w_in_fire;
    logic                    w_out_fire;
    logic                    w_hit;
    logic [PW-1:0]           w_pos_inc;
    logic [PW-1:0]           w_offset;
    logic [PW+15:0]          w_limit_ext;

    logic [MAX_PATTERN:0]    w_chain;
    logic [MAX_PATTERN-1:0]  w_hits;

    assign o_ready    = !r_skid_vld;
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = r_out_vld && i_ready;

    assign w_limit_ext = {PW'(0), i_data.search_limit};
    assign w_pos_inc   = r_pos + PW'(1);
    assign w_offset    = w_pos_inc - PW'(r_len);
    assign w_hit       = |w_hits;

    // cell chain: cell 0 sees a constant match from the left
    assign w_chain[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            bss_cell #(
                .INDEX (g),
                .LEN_W (LEN_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_len   (r_len),
                .i_prev  (w_chain[g]),
                .o_match (w_chain[g+1]),
                .o_hit   (w_hits[g])
            );
        end
    endgenerate

    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_limit = r_limit;
        n_found = r_found;
        n_dec   = r_dec;

        w_ctrl.clear     = 1'b0;
        w_ctrl.load      = 1'b0;
        w_ctrl.step      = 1'b0;
        w_ctrl.data_byte = i_data.data_byte;

        w_res.status       = bss_pkg::ST_ACCEPTED;
        w_res.match_offset = 16'd0;

        if (w_in_fire) begin
            unique case (i_data.mode)
                bss_pkg::MODE_START: begin
                    w_ctrl.clear = 1'b1;
                    n_len        = '0;
                    n_pos        = '0;
                    n_limit      = w_limit_ext[PW-1:0];
                    n_found      = '0;
                    n_dec        = bss_pkg::DEC_NONE;
                end
                bss_pkg::MODE_PATTERN: begin
                    if (i_data.data_byte == 8'd0 || r_dec != bss_pkg::DEC_NONE ||
                        r_pos != '0) begin
                        w_res.status = bss_pkg::ST_ACCEPTED;
                    end else if (r_len == LEN_W'(MAX_PATTERN)) begin
                        w_res.status = bss_pkg::ST_OVERFLOW;
                    end else begin
                        w_ctrl.load = 1'b1;
                        n_len       = r_len + LEN_W'(1);
                    end
                end
                bss_pkg::MODE_TEXT: begin
                    if (r_dec != bss_pkg::DEC_NONE) begin
                        n_dec = r_dec;
                    end else if (r_len == '0) begin
                        n_dec   = bss_pkg::DEC_FOUND;
                        n_found = '0;
                    end else if (i_data.data_byte == 8'd0 || r_pos >= r_limit) begin
                        n_dec = bss_pkg::DEC_MISSING;
                    end else begin
                        w_ctrl.step = 1'b1;
                        if (w_hit) begin
                            n_dec   = bss_pkg::DEC_FOUND;
                            n_found = w_offset;
                        end else begin
                            n_pos = w_pos_inc;
                            if (w_pos_inc >= r_limit) begin
                                n_dec = bss_pkg::DEC_MISSING;
                            end
                        end
                    end
                    // report the decision after this beat
                    unique case (n_dec)
                        bss_pkg::DEC_FOUND: begin
                            w_res.status       = bss_pkg::ST_FOUND;
                            w_res.match_offset = 16'(n_found);
                        end
                        bss_pkg::DEC_MISSING: begin
                            w_res.status = bss_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                            w_res.status = bss_pkg::ST_SEARCHING;
                        end
                    endcase
                end
                default: begin
                    w_res.status = bss_pkg::ST_ACCEPTED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pos   <= '0;
            r_limit <= '0;
            r_found <= '0;
            r_dec   <= bss_pkg::DEC_NONE;
        end else begin
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_limit <= n_limit;
            r_found <= n_found;
            r_dec   <= n_dec;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_fire) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_out_fire) begin
            r_out_vld <= w_in_fire;
            r_out     <= w_res;
        end else if (w_in_fire) begin
            r_skid     <= w_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire
